>>> rtl/core/generational_handle_allocator_macros.svh
// ----------------------------------------------------------------------------
// Generational handle allocator assertion macros
// Shared property wrappers for the handle allocator checks.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HGA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HGA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/hga_pkg.sv
// ----------------------------------------------------------------------------
// Handle allocator package
// Shared types, codes and constants of the generational handle allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hga_pkg;

  localparam int SLOTS_DEFAULT = 1024;
  localparam int NS_W          = 12;
  localparam int NS_SHIFT      = 20;
  localparam int HANDLE_W      = 32;
  localparam int GEN_W         = 32;
  localparam int STATUS_W      = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_STALE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [HANDLE_W-1:0] handle_index;
    logic [GEN_W-1:0]    handle_generation;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] result_index;
    logic [GEN_W-1:0]    result_generation;
  } rsp_t;

  // Control for the item held between decode and commit.
  typedef struct packed {
    logic valid;
    logic release_req;
    logic bad_handle;
  } hga_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/hga_ram.sv
// ----------------------------------------------------------------------------
// Handle allocator RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/hga_decode.sv
// ----------------------------------------------------------------------------
// Handle allocator decode
// Register the item, strip the namespace base and screen bad handles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hga_decode #(
  parameter int SLOTS = hga_pkg::SLOTS_DEFAULT,
  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire hga_pkg::req_t          request,
  input  wire logic [hga_pkg::NS_W-1:0] ns_id,
  output logic      [IDXW-1:0]        slot_raddr,
  output hga_pkg::hga_ctl_t           ctl,
  output logic      [IDXW-1:0]        slot,
  output logic      [hga_pkg::GEN_W-1:0] hgen
);

  import hga_pkg::*;

  logic [HANDLE_W-1:0] base;
  logic [HANDLE_W-1:0] offset;
  logic                bad;

  always_comb begin
    base   = HANDLE_W'(ns_id) << NS_SHIFT;
    offset = request.handle_index - base;
    bad    = (request.handle_generation == '0) ||
             (request.handle_index < base) ||
             (offset >= HANDLE_W'(SLOTS));
  end

  // Slot table is read at the raw offset; the commit stage ignores it when bad.
  assign slot_raddr = offset[IDXW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= accept;
    end
    ctl.release_req <= (request.req_type == REQ_RELEASE);
    ctl.bad_handle  <= bad;
    slot            <= offset[IDXW-1:0];
    hgen            <= request.handle_generation;
  end

endmodule

`default_nettype wire

>>> rtl/core/hga_commit.sv
// ----------------------------------------------------------------------------
// Handle allocator commit
// Resolve the item against the tables, update state, register the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hga_commit #(
  parameter int SLOTS = hga_pkg::SLOTS_DEFAULT,
  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CNTW = $clog2(SLOTS + 1),
  localparam int SW   = hga_pkg::GEN_W + 1,
  localparam int KW   = IDXW + hga_pkg::GEN_W
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [hga_pkg::NS_W-1:0]  ns_id,
  input  wire hga_pkg::hga_ctl_t         ctl,
  input  wire logic [IDXW-1:0]           slot,
  input  wire logic [hga_pkg::GEN_W-1:0] hgen,
  input  wire logic [IDXW-1:0]           slot_raddr,
  input  wire logic [SW-1:0]             slot_rdata,
  input  wire logic [KW-1:0]             stk_rdata,
  output logic                           slot_we,
  output logic      [IDXW-1:0]           slot_waddr,
  output logic      [SW-1:0]             slot_wdata,
  output logic                           stk_we,
  output logic      [IDXW-1:0]           stk_waddr,
  output logic      [KW-1:0]             stk_wdata,
  output logic      [IDXW-1:0]           stk_raddr,
  output logic                           done,
  output hga_pkg::rsp_t                  result
);

  import hga_pkg::*;

  logic [CNTW-1:0]     free_count, free_count_next;
  logic [CNTW-1:0]     slots_used, slots_used_next;
  logic                slot_byp, stk_byp;
  logic [SW-1:0]       slot_byp_data;
  logic [KW-1:0]       stk_byp_data;
  logic [SW-1:0]       slot_cur;
  logic [KW-1:0]       stk_cur;
  logic [IDXW-1:0]     pop_slot;
  logic [GEN_W-1:0]    pop_gen, bump_gen;
  logic [HANDLE_W-1:0] base;
  logic                rel_ok;
  rsp_t                rsp_next;

  always_comb begin
    slot_cur = slot_byp ? slot_byp_data : slot_rdata;
    stk_cur  = stk_byp ? stk_byp_data : stk_rdata;
    pop_slot = stk_cur[KW-1:GEN_W];
    pop_gen  = stk_cur[GEN_W-1:0];
    base     = HANDLE_W'(ns_id) << NS_SHIFT;
    bump_gen = hgen + GEN_W'(1);
    if (bump_gen == '0) begin
      bump_gen = GEN_W'(1);
    end
    rel_ok = !ctl.bad_handle && (CNTW'(slot) < slots_used) &&
             slot_cur[GEN_W] && (slot_cur[GEN_W-1:0] == hgen);

    free_count_next = free_count;
    slots_used_next = slots_used;
    slot_we         = 1'b0;
    slot_waddr      = slot;
    slot_wdata      = '0;
    stk_we          = 1'b0;
    stk_waddr       = free_count[IDXW-1:0];
    stk_wdata       = {slot, bump_gen};
    rsp_next        = '{status: STATUS_OK, result_index: '0, result_generation: '0};

    if (ctl.valid) begin
      if (!ctl.release_req) begin
        priority if (free_count != '0) begin
          // Reuse the most recently freed slot with its stored generation.
          free_count_next = free_count - CNTW'(1);
          slot_we         = 1'b1;
          slot_waddr      = pop_slot;
          slot_wdata      = {1'b1, pop_gen};
          rsp_next.result_index      = base + HANDLE_W'(pop_slot);
          rsp_next.result_generation = pop_gen;
        end else if (slots_used != CNTW'(SLOTS)) begin
          slots_used_next = slots_used + CNTW'(1);
          slot_we         = 1'b1;
          slot_waddr      = slots_used[IDXW-1:0];
          slot_wdata      = {1'b1, GEN_W'(1)};
          rsp_next.result_index      = base + HANDLE_W'(slots_used);
          rsp_next.result_generation = GEN_W'(1);
        end else begin
          rsp_next.status = STATUS_FULL;
        end
      end else if (rel_ok) begin
        slot_we    = 1'b1;
        slot_wdata = {1'b0, bump_gen};
        if (free_count != CNTW'(SLOTS)) begin
          stk_we          = 1'b1;
          free_count_next = free_count + CNTW'(1);
        end
      end else begin
        rsp_next.status = STATUS_STALE;
      end
    end
  end

  // Next pop reads the stack top as it stands after this commit.
  assign stk_raddr = IDXW'(free_count_next - CNTW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= '0;
      slots_used <= '0;
      done       <= 1'b0;
    end else begin
      free_count <= free_count_next;
      slots_used <= slots_used_next;
      done       <= ctl.valid;
    end
    result        <= rsp_next;
    slot_byp      <= slot_we && (slot_waddr == slot_raddr);
    slot_byp_data <= slot_wdata;
    stk_byp       <= stk_we && (stk_waddr == stk_raddr);
    stk_byp_data  <= stk_wdata;
  end

endmodule

`default_nettype wire

>>> rtl/core/generational_handle_allocator.sv
// Order: the item is registered in the decode stage, then done and the result
// are registered in the commit stage. Throughput: one item per cycle; busy never
// rises, since the slot RAM is read on the accept edge, the stack top is read
// ahead at each commit, and both are forwarded around their own write. The
// receiver cannot stall: done is high for exactly one cycle per item. Reset
// clears the counters, the namespace and the valid and done flags only.
// ----------------------------------------------------------------------------
// Generational handle allocator
// Hands out index and generation handles from a LIFO free list of slots, or from fresh slots when it is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "generational_handle_allocator_macros.svh"

module generational_handle_allocator #(
  parameter int SLOTS = hga_pkg::SLOTS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire hga_pkg::req_t            request,
  output logic                          done,
  output hga_pkg::rsp_t                 result,
  input  wire logic                     cfg_write,
  input  wire logic [hga_pkg::NS_W-1:0] cfg_data
);

  import hga_pkg::*;

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW   = GEN_W + 1;     // live bit over generation
  localparam int KW   = IDXW + GEN_W;  // stacked slot over its next generation

  logic [NS_W-1:0]  ns_id;
  logic             accept;
  hga_ctl_t         ctl;
  logic [IDXW-1:0]  slot;
  logic [GEN_W-1:0] hgen;
  logic [IDXW-1:0]  slot_raddr;
  logic [SW-1:0]    slot_rdata;
  logic             slot_we;
  logic [IDXW-1:0]  slot_waddr;
  logic [SW-1:0]    slot_wdata;
  logic [KW-1:0]    stk_rdata;
  logic             stk_we;
  logic [IDXW-1:0]  stk_waddr;
  logic [KW-1:0]    stk_wdata;
  logic [IDXW-1:0]  stk_raddr;

  // Every cycle can take an item: each item touches one slot and the stack top.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Hold the namespace; the user must write it only while idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      ns_id <= '0;
    end else if (cfg_write) begin
      ns_id <= cfg_data;
    end
  end

  // Decode: register the item and launch the slot table read at its offset.
  hga_decode #(.SLOTS(SLOTS)) u_decode (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .request      (request),
    .ns_id        (ns_id),
    .slot_raddr   (slot_raddr),
    .ctl          (ctl),
    .slot         (slot),
    .hgen         (hgen)
  );

  // Slot table: live bit and generation. Entries at or above slots_used are
  // never read as meaningful, so the fill count stands in for a reset.
  hga_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // Free stack: each entry carries the slot and the generation it reissues with,
  // so a pop needs no second table read.
  hga_ram #(.WIDTH(KW), .DEPTH(SLOTS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Commit: check the handle, update tables and counters, register the result.
  hga_commit #(.SLOTS(SLOTS)) u_commit (
    .clk          (clk),
    .rst          (rst),
    .ns_id        (ns_id),
    .ctl          (ctl),
    .slot         (slot),
    .hgen         (hgen),
    .slot_raddr   (slot_raddr),
    .slot_rdata   (slot_rdata),
    .stk_rdata    (stk_rdata),
    .slot_we      (slot_we),
    .slot_waddr   (slot_waddr),
    .slot_wdata   (slot_wdata),
    .stk_we       (stk_we),
    .stk_waddr    (stk_waddr),
    .stk_wdata    (stk_wdata),
    .stk_raddr    (stk_raddr),
    .done         (done),
    .result       (result)
  );

  // Every accepted item answers with done, after the decode and commit registers.
  `HGA_ASSERT_NEXT(a_item_answers, clk, rst, accept, ##1 done, "accepted item got no result")
  // No result without an item accepted ahead of the decode and commit registers.
  `HGA_ASSERT_NOW(a_no_spurious, clk, rst, done, $past(accept, 2), "result without an item")
  // Failed requests carry no handle.
  `HGA_ASSERT_NOW(a_fail_zero, clk, rst, done && (result.status != STATUS_OK), (result.result_index == '0) && (result.result_generation == '0), "failed request returned a handle")

endmodule

`default_nettype wire
